### rtl/jmss_pkg.sv
// ----------------------------------------------------------------------------
// JPEG marker section splitter package
// Shared payload types, marker codes and sizing constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jmss_pkg;

   localparam int MaxSectionsDefault = 16;
   localparam int FifoDepth          = 8;

   localparam logic [7:0] MARKER_PREFIX = 8'hFF;
   localparam logic [7:0] CODE_EOI      = 8'hD9;
   localparam logic [7:0] CODE_SOF0     = 8'hC0;
   localparam logic [7:0] CODE_DHT      = 8'hC4;
   localparam logic [7:0] CODE_SOS      = 8'hDA;
   localparam logic [7:0] CODE_DQT      = 8'hDB;

   localparam logic KIND_SECTION = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic        record_kind;
      logic        segment;
      logic [7:0]  marker_code;
      logic [31:0] start_offset;
      logic [31:0] section_length;
      logic [3:0]  section_index;
      logic        keep_segment;
      logic        overflow;
      logic        end_of_run;
   } rsp_payload_type;

   // Results produced by one byte, handed to the output queue.
   typedef struct packed {
      logic [1:0]      count;
      rsp_payload_type first;
      rsp_payload_type second;
   } push_type;

   function automatic logic is_important(input logic [7:0] code);
      is_important = (code == CODE_SOF0) || (code == CODE_DHT) ||
                     (code == CODE_SOS)  || (code == CODE_DQT);
   endfunction

endpackage

`default_nettype wire

### rtl/jmss_parser.sv
// ----------------------------------------------------------------------------
// JPEG marker section splitter: byte parser
// Input register, marker detection and section bookkeeping for one byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jmss_parser #(
   parameter int MAX_SECTIONS = jmss_pkg::MaxSectionsDefault
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       in_accept,
   input  jmss_pkg::req_payload_type in_data,
   output logic                      busy,
   output jmss_pkg::push_type        push
);
   import jmss_pkg::*;

   // The count is at least four bits wide so that the index always has a
   // full four-bit slice to take from.
   localparam int CW = ($clog2(MAX_SECTIONS + 2) > 4) ? $clog2(MAX_SECTIONS + 2) : 4;
   localparam logic [CW-1:0] MAX_C  = CW'(MAX_SECTIONS);
   localparam logic [CW-1:0] MAX_C1 = CW'(MAX_SECTIONS + 1);

   logic            in_v_ff;
   req_payload_type in_d_ff;

   logic [7:0]    prev_ff, prev_in;
   logic [31:0]   pos_ff, pos_in;
   logic [1:0]    eoi_ff, eoi_in;
   logic          open_ff, open_in;
   logic [7:0]    omark_ff, omark_in;
   logic [31:0]   ostart_ff, ostart_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          tmany_ff, tmany_in;

   logic            marker, close;
   logic [31:0]     mstart;
   logic [CW-1:0]   idx_full;
   logic [3:0]      idx;
   logic            keep;
   rsp_payload_type sec_rec, sum_rec;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else begin
         in_v_ff <= in_accept;
      end
      if (in_accept) begin
         in_d_ff <= in_data;
      end
   end

   assign busy = in_v_ff;

   always_comb begin
      marker   = (eoi_ff < 2'd2) && (prev_ff == MARKER_PREFIX) &&
                 (in_d_ff.data_byte != 8'd0);
      close    = marker && open_ff;
      mstart   = pos_ff - 32'd1;
      idx_full = (cnt_ff != '0) ? cnt_ff - CW'(1) : '0;
      idx      = (idx_full > CW'(15)) ? 4'd15 : idx_full[3:0];

      prev_in   = in_d_ff.data_byte;
      pos_in    = pos_ff + 32'd1;
      eoi_in    = eoi_ff;
      open_in   = open_ff;
      omark_in  = omark_ff;
      ostart_in = ostart_ff;
      cnt_in    = cnt_ff;
      tmany_in  = tmany_ff;

      if (marker) begin
         if (open_ff) begin
            open_in = 1'b0;
         end
         if (in_d_ff.data_byte == CODE_EOI) begin
            eoi_in = eoi_ff + 2'd1;
            cnt_in = '0;
         end else if (is_important(in_d_ff.data_byte)) begin
            if (cnt_ff >= MAX_C) begin
               tmany_in = 1'b1;
               cnt_in   = MAX_C1;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
            open_in   = 1'b1;
            omark_in  = in_d_ff.data_byte;
            ostart_in = mstart;
         end
      end

      // The summary sees the EOI count after this byte.
      keep = (eoi_in >= 2'd2);

      sec_rec.record_kind    = KIND_SECTION;
      sec_rec.segment        = eoi_ff[0];
      sec_rec.marker_code    = omark_ff;
      sec_rec.start_offset   = ostart_ff;
      sec_rec.section_length = mstart - ostart_ff;
      sec_rec.section_index  = idx;
      sec_rec.keep_segment   = 1'b0;
      sec_rec.overflow       = 1'b0;
      sec_rec.end_of_run     = !in_d_ff.last_byte;

      sum_rec.record_kind    = KIND_SUMMARY;
      sum_rec.segment        = keep;
      sum_rec.marker_code    = 8'd0;
      sum_rec.start_offset   = 32'd0;
      sum_rec.section_length = 32'd0;
      sum_rec.section_index  = 4'd0;
      sum_rec.keep_segment   = keep;
      sum_rec.overflow       = tmany_in;
      sum_rec.end_of_run     = 1'b1;

      push.count  = in_v_ff ? ({1'b0, close} + {1'b0, in_d_ff.last_byte}) : 2'd0;
      push.first  = close ? sec_rec : sum_rec;
      push.second = sum_rec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= 8'd0;
         pos_ff    <= 32'd0;
         eoi_ff    <= 2'd0;
         open_ff   <= 1'b0;
         omark_ff  <= 8'd0;
         ostart_ff <= 32'd0;
         cnt_ff    <= '0;
         tmany_ff  <= 1'b0;
      end else if (in_v_ff) begin
         if (in_d_ff.last_byte) begin
            // The final byte returns everything to the start-of-stream state.
            prev_ff   <= 8'd0;
            pos_ff    <= 32'd0;
            eoi_ff    <= 2'd0;
            open_ff   <= 1'b0;
            omark_ff  <= 8'd0;
            ostart_ff <= 32'd0;
            cnt_ff    <= '0;
            tmany_ff  <= 1'b0;
         end else begin
            prev_ff   <= prev_in;
            pos_ff    <= pos_in;
            eoi_ff    <= eoi_in;
            open_ff   <= open_in;
            omark_ff  <= omark_in;
            ostart_ff <= ostart_in;
            cnt_ff    <= cnt_in;
            tmany_ff  <= tmany_in;
         end
      end
   end

endmodule

`default_nettype wire

### rtl/jmss_out_queue.sv
// ----------------------------------------------------------------------------
// JPEG marker section splitter: output queue
// Small record queue: up to two records in per cycle, one out when rsp_ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jmss_out_queue (
   input  wire                        clock,
   input  wire                        reset,
   input  jmss_pkg::push_type         push,
   input  wire                        busy,
   output logic                       space_ok,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output jmss_pkg::rsp_payload_type  rsp_data
);
   import jmss_pkg::*;

   localparam int AW = $clog2(FifoDepth);
   localparam int LW = $clog2(FifoDepth + 1);

   rsp_payload_type mem [FifoDepth];

   logic [AW-1:0] wr_ff, wr_in;
   logic [AW-1:0] rd_ff, rd_in;
   logic [LW-1:0] level_ff, level_in;
   logic          pop;
   logic [AW-1:0] wr_next;

   assign rsp_valid = (level_ff != '0);
   assign rsp_data  = mem[rd_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign wr_next   = wr_ff + AW'(1);

   // A new byte is taken only if the queue can still absorb two records from
   // the byte now in the parser and two from the new one.
   assign space_ok = ({1'b0, level_ff} + {{(LW - 1){1'b0}}, busy, 1'b0}) <=
                     (LW + 1)'(FifoDepth - 2);

   always_comb begin
      wr_in    = wr_ff + AW'(push.count);
      rd_in    = pop ? rd_ff + AW'(1) : rd_ff;
      level_in = level_ff + LW'(push.count) - LW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         level_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         level_ff <= level_in;
      end
   end

endmodule

`default_nettype wire

### rtl/jpeg_marker_section_splitter.sv
// ----------------------------------------------------------------------------
// JPEG marker section splitter
// Splits a JPEG byte stream into sections at important markers.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one stream byte per beat with a flag on the final
//   byte. The rsp channel carries records: one per closed section (opened by
//   SOF0, DHT, SOS or DQT, closed by the next marker) and a summary record on
//   the final byte that names the segment to keep and flags section overflow.
//   A byte yields zero, one or two records; end_of_run marks the last of them.
//   Throughput is one byte per cycle, set by the per-byte parser register,
//   while req_ready stays high. A record reaches rsp through the input
//   register and then the output queue; the two records of one byte leave
//   rsp one at a time.
//   When the receiver stalls, records collect in an eight-entry queue and
//   req_ready drops once the queue cannot take two more bytes' worth.
//   Synchronous reset empties the queue and clears the stream state; the
//   state also returns to its start value after each final byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jpeg_marker_section_splitter #(
   parameter int MAX_SECTIONS = jmss_pkg::MaxSectionsDefault
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  jmss_pkg::req_payload_type  req_data,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output jmss_pkg::rsp_payload_type  rsp_data
);
   import jmss_pkg::*;

   push_type push;
   logic     busy;
   logic     space_ok;
   logic     in_accept;

   assign req_ready = space_ok;
   assign in_accept = req_valid && req_ready;

   jmss_parser #(
      .MAX_SECTIONS(MAX_SECTIONS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_accept (in_accept),
      .in_data   (req_data),
      .busy      (busy),
      .push      (push)
   );

   jmss_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .busy      (busy),
      .space_ok  (space_ok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### rtl/jmss_checker.sv
// ----------------------------------------------------------------------------
// JPEG marker section splitter checker
// Port-level checks on record contents and on both handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jmss_checker (
   input wire                       clock,
   input wire                       reset,
   input wire                       req_valid,
   input wire                       req_ready,
   input jmss_pkg::req_payload_type req_data,
   input wire                       rsp_valid,
   input wire                       rsp_ready,
   input jmss_pkg::rsp_payload_type rsp_data
);
   import jmss_pkg::*;

   // Reset empties the queue, so no record shows in the following cycle.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("record present right after reset");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("waiting byte changed or vanished");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled record changed or vanished");

   a_summary_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.record_kind == KIND_SUMMARY) |->
         rsp_data.end_of_run && (rsp_data.segment == rsp_data.keep_segment) &&
         (rsp_data.marker_code == 8'd0))
      else $error("malformed summary record");

   a_section_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.record_kind == KIND_SECTION) |->
         !rsp_data.keep_segment && !rsp_data.overflow &&
         is_important(rsp_data.marker_code))
      else $error("malformed section record");

endmodule

bind jpeg_marker_section_splitter jmss_checker u_jmss_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
